### design/stereo_mix_accumulator_core_assert.svh
// Assertion helpers for the stereo mixer core.
// Both expect clk_i and rst_ni in scope.
`ifndef STEREO_MIX_ACCUMULATOR_CORE_ASSERT_SVH
`define STEREO_MIX_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define SMIX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SMIX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/smix_pkg.sv
`default_nettype none

package smix_pkg;

  localparam int FRAME_SAMPLES = 256;
  localparam int ACC_WIDTH     = 24;
  localparam int IDX_W         = $clog2(FRAME_SAMPLES);
  localparam int POS_RANGE     = 256;
  localparam int OUT_DEPTH     = 3;
  localparam int OPTR_W        = 2;
  localparam int CNT_W         = 2;

  localparam logic [15:0] GAIN_RESET = 16'd21627;

  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic signed [ACC_WIDTH-1:0] acc_t;
  typedef logic signed [16:0]          term_t;

  typedef struct packed {
    acc_t left;
    acc_t right;
  } entry_t;

  typedef struct packed {
    logic              clip;
    logic signed [15:0] val;
  } sat16_t;

  typedef struct packed {
    logic [7:0]         position;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               clipped;
  } out_item_t;

  typedef idx_t idx_lut_t [POS_RANGE];

  function automatic idx_lut_t build_idx_lut();
    idx_lut_t lut;
    for (int i = 0; i < POS_RANGE; i++) begin
      lut[i] = idx_t'(i % FRAME_SAMPLES);
    end
    return lut;
  endfunction

  localparam idx_lut_t IDX_LUT = build_idx_lut();

  // Q1.15 sample times Q0.16 gain, rounded half up to Q1.15.
  function automatic term_t scale(logic signed [15:0] sample, logic [15:0] gain);
    logic signed [32:0] prod;
    logic signed [32:0] biased;
    prod   = 33'(sample) * $signed({17'd0, gain});
    biased = prod + 33'sd32768;
    return biased[32:16];
  endfunction

  function automatic acc_t acc_add(acc_t acc, term_t term);
    logic signed [ACC_WIDTH:0] sum;
    sum = (ACC_WIDTH+1)'(acc) + (ACC_WIDTH+1)'(term);
    if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
      return sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end
    return sum[ACC_WIDTH-1:0];
  endfunction

  function automatic sat16_t sat16(acc_t a);
    sat16_t r;
    if (a > acc_t'(32767)) begin
      r.clip = 1'b1;
      r.val  = 16'sh7fff;
    end else if (a < acc_t'(-32768)) begin
      r.clip = 1'b1;
      r.val  = 16'sh8000;
    end else begin
      r.clip = 1'b0;
      r.val  = a[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/smix_if.sv
`default_nettype none

interface smix_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         sample_position;
  logic signed [15:0] source_left;
  logic signed [15:0] source_right;
  logic               final_source;

  modport source (output valid, sample_position, source_left, source_right, final_source,
                  input ready);
  modport sink (input valid, sample_position, source_left, source_right, final_source,
                output ready);
endinterface

interface smix_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         mixed_position;
  logic signed [15:0] mixed_left;
  logic signed [15:0] mixed_right;
  logic               clipped;

  modport source (output valid, mixed_position, mixed_left, mixed_right, clipped,
                  input ready);
  modport sink (input valid, mixed_position, mixed_left, mixed_right, clipped,
                output ready);
endinterface

interface smix_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] mix_gain;

  modport source (output valid, mix_gain, input ready);
  modport sink (input valid, mix_gain, output ready);
endinterface

`default_nettype wire

### design/stereo_mix_accumulator_core.sv
`default_nettype none

`include "stereo_mix_accumulator_core_assert.svh"

// Stereo mixer: each input beat adds one source's gain-scaled left/right pair into the
// accumulator entry for its frame position; a beat flagged final_source emits the saturated
// sum (including that beat) and clears the entry. Throughput is one beat per cycle while in
// ready is high: each beat is one read-modify-write of a single-port-read, single-port-write
// accumulator memory (FRAME_SAMPLES entries), read at accept, updated and written back the
// next cycle, with forwarding when consecutive beats hit the same position. Each result is
// registered from that update stage into a 3-entry queue, and in ready is low while the
// queue would fill, so in ready depends only on internal registers. After reset the memory
// is swept to zero entry by entry (FRAME_SAMPLES entries, 256 at the default) with in ready
// low. The gain register is always ready and should be written only while no beat is in flight.
module stereo_mix_accumulator_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  smix_cfg_if.sink    cfg_i,
  smix_in_if.sink     in_i,
  smix_out_if.source  out_o
);

  logic [15:0] gain_q;

  logic               clr_busy_q;
  smix_pkg::idx_t     clr_cnt_q;

  smix_pkg::entry_t   mem_q [smix_pkg::FRAME_SAMPLES];
  smix_pkg::entry_t   rd_data_q;
  logic               mem_we;
  smix_pkg::idx_t     mem_waddr;
  smix_pkg::entry_t   mem_wdata;

  logic               s1_v_q;
  logic [7:0]         s1_pos_q;
  smix_pkg::idx_t     s1_idx_q;
  logic               s1_final_q;
  smix_pkg::term_t    term_l_q;
  smix_pkg::term_t    term_r_q;
  logic               fwd_q;
  smix_pkg::entry_t   fwd_data_q;

  smix_pkg::out_item_t              ofifo_q [smix_pkg::OUT_DEPTH];
  logic [smix_pkg::OPTR_W-1:0]      wr_ptr_q;
  logic [smix_pkg::OPTR_W-1:0]      rd_ptr_q;
  logic [smix_pkg::CNT_W-1:0]       cnt_q;

  logic               in_fire;
  logic               push;
  logic               pop;
  smix_pkg::idx_t     in_idx;
  smix_pkg::entry_t   cur;
  smix_pkg::entry_t   upd;
  smix_pkg::sat16_t   sat_l;
  smix_pkg::sat16_t   sat_r;
  smix_pkg::out_item_t head;

  assign cfg_i.ready = 1'b1;

  assign in_idx  = smix_pkg::IDX_LUT[in_i.sample_position];
  assign in_i.ready = !clr_busy_q &&
                      (({1'b0, cnt_q} + (smix_pkg::CNT_W+1)'(s1_v_q && s1_final_q))
                       < (smix_pkg::CNT_W+1)'(smix_pkg::OUT_DEPTH));
  assign in_fire = in_i.valid && in_i.ready;

  assign push = s1_v_q && s1_final_q;
  assign pop  = out_o.valid && out_o.ready;

  always_comb begin
    cur       = fwd_q ? fwd_data_q : rd_data_q;
    upd.left  = smix_pkg::acc_add(cur.left, term_l_q);
    upd.right = smix_pkg::acc_add(cur.right, term_r_q);
    sat_l     = smix_pkg::sat16(upd.left);
    sat_r     = smix_pkg::sat16(upd.right);

    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_v_q;
      mem_waddr = s1_idx_q;
      mem_wdata = s1_final_q ? '0 : upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_data_q <= mem_q[in_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pos_q   <= in_i.sample_position;
      s1_idx_q   <= in_idx;
      s1_final_q <= in_i.final_source;
      term_l_q   <= smix_pkg::scale(in_i.source_left, gain_q);
      term_r_q   <= smix_pkg::scale(in_i.source_right, gain_q);
    end
    fwd_data_q <= mem_wdata;
    if (push) begin
      ofifo_q[wr_ptr_q] <= '{position: s1_pos_q, left: sat_l.val, right: sat_r.val,
                             clipped: sat_l.clip || sat_r.clip};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= smix_pkg::GAIN_RESET;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      s1_v_q     <= 1'b0;
      fwd_q      <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        gain_q <= cfg_i.mix_gain;
      end
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == smix_pkg::idx_t'(smix_pkg::FRAME_SAMPLES - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      s1_v_q <= in_fire;
      fwd_q  <= s1_v_q && (s1_idx_q == in_idx);
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == smix_pkg::OPTR_W'(smix_pkg::OUT_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == smix_pkg::OPTR_W'(smix_pkg::OUT_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head                 = ofifo_q[rd_ptr_q];
  assign out_o.valid          = (cnt_q != '0);
  assign out_o.mixed_position = head.position;
  assign out_o.mixed_left     = head.left;
  assign out_o.mixed_right    = head.right;
  assign out_o.clipped        = head.clipped;

  `SMIX_ASSERT_NOW(a_no_queue_overflow, push, (cnt_q != smix_pkg::CNT_W'(smix_pkg::OUT_DEPTH)) || pop, "result pushed into full output queue")
  `SMIX_ASSERT_NOW(a_clear_idle, clr_busy_q, !s1_v_q, "read-modify-write during clearing sweep")
  `SMIX_ASSERT_NEXT(a_result_visible, push, out_o.valid, "final beat produced no visible result")

endmodule

`default_nettype wire

### bench/tb_top.sv
`default_nettype none

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BEATS    = 280;
  localparam int OVERFLOW_BEATS = 270;

  class mixer_scoreboard;
    longint               sum_left  [smix_pkg::FRAME_SAMPLES];
    longint               sum_right [smix_pkg::FRAME_SAMPLES];
    logic [15:0]          gain;
    smix_pkg::out_item_t  pending_mixes [$];
    int                   errors;

    function new();
      foreach (sum_left[i]) begin
        sum_left[i]  = 0;
        sum_right[i] = 0;
      end
      gain   = smix_pkg::GAIN_RESET;
      errors = 0;
    endfunction

    // Q1.15 x Q0.16, rounded half up back to Q1.15
    function longint scaled_term(logic signed [15:0] s);
      longint p;
      p = longint'(s) * longint'({48'd0, gain});
      return (p + 32768) >>> 16;
    endfunction

    function longint acc_limit(longint v);
      longint lim;
      lim = longint'(1) <<< (smix_pkg::ACC_WIDTH - 1);
      if (v > lim - 1) return lim - 1;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function logic signed [15:0] to_q15(longint v, output bit hit);
      hit = 1'b1;
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      hit = 1'b0;
      return v[15:0];
    endfunction

    function void note_beat(logic [7:0] pos, logic signed [15:0] l, logic signed [15:0] r,
                            logic last_src);
      int                  idx;
      bit                  hit_l;
      bit                  hit_r;
      smix_pkg::out_item_t m;
      idx = pos % smix_pkg::FRAME_SAMPLES;
      sum_left[idx]  = acc_limit(sum_left[idx] + scaled_term(l));
      sum_right[idx] = acc_limit(sum_right[idx] + scaled_term(r));
      if (!last_src) return;
      m.position = pos;
      m.left     = to_q15(sum_left[idx], hit_l);
      m.right    = to_q15(sum_right[idx], hit_r);
      m.clipped  = hit_l | hit_r;
      sum_left[idx]  = 0;
      sum_right[idx] = 0;
      pending_mixes = {pending_mixes, m};
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(smix_pkg::out_item_t got);
      smix_pkg::out_item_t want;
      if (pending_mixes.size() == 0) begin
        report($sformatf("unexpected mix pos=%0d l=%0d r=%0d clip=%0b",
                         got.position, got.left, got.right, got.clipped));
        return;
      end
      want = pending_mixes.pop_front();
      if (got.position !== want.position)
        report($sformatf("mixed_position got %0d want %0d", got.position, want.position));
      if (got.left !== want.left)
        report($sformatf("mixed_left pos %0d got %0d want %0d",
                         want.position, got.left, want.left));
      if (got.right !== want.right)
        report($sformatf("mixed_right pos %0d got %0d want %0d",
                         want.position, got.right, want.right));
      if (got.clipped !== want.clipped)
        report($sformatf("clipped pos %0d got %0b want %0b",
                         want.position, got.clipped, want.clipped));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  smix_cfg_if cfg_if ();
  smix_in_if  in_if ();
  smix_out_if out_if ();

  stereo_mix_accumulator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  mixer_scoreboard sb = new();

  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  int beats_sent;
  int stall_left;
  int idle_cycles;

  initial begin
    clk_i                  = 1'b0;
    rst_ni                 = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.mix_gain        = '0;
    in_if.valid            = 1'b0;
    in_if.sample_position  = '0;
    in_if.source_left      = '0;
    in_if.source_right     = '0;
    in_if.final_source     = 1'b0;
    out_if.ready           = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // result sink stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0 && stalls_on) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        out_if.ready <= 1'b1;
        stall_left = 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result('{out_if.mixed_position, out_if.mixed_left, out_if.mixed_right,
                        out_if.clipped});
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("** stereo_mix_accumulator_core: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(logic [7:0] pos, logic signed [15:0] l, logic signed [15:0] r,
                           logic last_src);
    int n;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid           <= 1'b1;
    in_if.sample_position <= pos;
    in_if.source_left     <= l;
    in_if.source_right    <= r;
    in_if.final_source    <= last_src;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_beat(pos, l, r, last_src);
    beats_sent++;
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  task automatic drain();
    go_idle();
    while (sb.pending_mixes.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_gain(logic [15:0] g);
    drain();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid    <= 1'b1;
    cfg_if.mix_gain <= g;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.gain = g;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_mix(int budget, bit pause_midway);
    int          start;
    int          n;
    logic [7:0]  pos;
    bit          paused;
    start  = beats_sent;
    paused = 1'b0;
    while (beats_sent - start < budget) begin
      if (pause_midway && !paused && beats_sent - start >= budget / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) begin
        pos = 8'($urandom);
        n   = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          send_beat(pos, rand_sample(), rand_sample(), i == n - 1);
      end else begin
        send_beat(8'($urandom_range(0, 7)), rand_sample(), rand_sample(),
                  $urandom_range(0, 2) == 0);
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset gain
    send_beat(8'd0, 16'sh7fff, 16'sh8000, 1'b1);
    send_beat(8'd255, 16'sh8000, 16'sh7fff, 1'b0);
    send_beat(8'd255, 16'sh8000, 16'sh7fff, 1'b1);
    send_beat(8'd1, 16'sh0000, 16'sh0000, 1'b1);
    send_beat(8'd2, 16'sh0001, -16'sh0001, 1'b1);
    for (int i = 0; i < 4; i++)
      send_beat(8'd3, 16'sh7fff, 16'sh8000, i == 3);
    send_beat(8'd4, 16'sh5555, 16'shaaaa, 1'b0);
    send_beat(8'd5, 16'shaaaa, 16'sh5555, 1'b0);
    send_beat(8'd4, 16'sh1234, -16'sh1234, 1'b1);
    send_beat(8'd5, 16'sh00ff, 16'shff00, 1'b1);
    send_beat(8'd128, 16'sh7fff, 16'sh7fff, 1'b1);

    set_gain(16'hffff);
    for (int i = 0; i < OVERFLOW_BEATS; i++)
      send_beat(8'd77, 16'sh7fff, 16'sh8000, i == OVERFLOW_BEATS - 1);
    send_beat(8'd6, 16'sh7fff, 16'sh8000, 1'b1);
    send_beat(8'd7, 16'sh7fff, 16'sh7fff, 1'b0);
    send_beat(8'd7, 16'sh7fff, 16'sh7fff, 1'b1);
    random_mix(PHASE_BEATS, 1'b0);

    set_gain(16'h0000);
    send_beat(8'd8, 16'sh7fff, 16'sh8000, 1'b1);
    random_mix(PHASE_BEATS, 1'b0);

    // exact halves round up
    set_gain(16'h8000);
    send_beat(8'd10, 16'sh0001, -16'sh0001, 1'b1);
    send_beat(8'd11, 16'sh0003, -16'sh0003, 1'b1);
    random_mix(PHASE_BEATS, 1'b1);

    set_gain(smix_pkg::GAIN_RESET);
    random_mix(PHASE_BEATS, 1'b0);

    set_gain(16'($urandom));
    random_mix(PHASE_BEATS, 1'b0);

    set_gain(16'($urandom));
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    random_mix(PHASE_BEATS, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.pending_mixes.size() != 0)
      sb.report($sformatf("%0d expected mixes never arrived", sb.pending_mixes.size()));
    if (sb.errors == 0)
      $display("** stereo_mix_accumulator_core: PASSED **");
    else
      $display("** stereo_mix_accumulator_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
